### rtl/matrix3_inverse_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef MATRIX3_INVERSE_MACROS_SVH
`define MATRIX3_INVERSE_MACROS_SVH

// same-cycle implication
`define M3I_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define M3I_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/m3i_pkg.sv
package m3i_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W         = 32;
  localparam int N_EL      = 9;
  localparam int QB        = W + FRAC_BITS;
  localparam int ACC_W     = 80;
  // cofactor 2, determinant 2, divider prep 1, quotient bits, divider final 1, output 1
  localparam int NSTG      = QB + 7;

  typedef logic [W-1:0] word_t;
  typedef logic [N_EL-1:0][W-1:0] mat_t;

  typedef struct packed {
    word_t det;
    logic  sing;
  } side_t;

  // round to nearest (halves up) at FRAC_BITS and saturate to the word range
  function automatic word_t round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] lim_hi;
    logic signed [ACC_W-1:0] lim_lo;
    t      = (v + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    lim_hi = ACC_W'({1'b0, {(W-1){1'b1}}});
    lim_lo = -lim_hi - ACC_W'(1);
    if (t > lim_hi) begin
      return {1'b0, {(W-1){1'b1}}};
    end else if (t < lim_lo) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return t[W-1:0];
    end
  endfunction

endpackage

### rtl/m3i_cof.sv
module m3i_cof (
  input  logic          clk,
  input  logic          en,
  input  m3i_pkg::mat_t a,
  output m3i_pkg::mat_t cof
);
  import m3i_pkg::*;

  logic signed [2*W-1:0] p1_r [N_EL];
  logic signed [2*W-1:0] p2_r [N_EL];
  mat_t                  cof_r;

  // cofactor of row r, column c kept at index r*3+c, so the array is the adjugate
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int R0 = (r == 0) ? 1 : 0;
      localparam int R1 = (r == 2) ? 1 : 2;
      localparam int C0 = (c == 0) ? 1 : 0;
      localparam int C1 = (c == 2) ? 1 : 2;
      localparam int K  = r * 3 + c;
      localparam bit ODD = ((r + c) % 2) == 1;

      logic signed [2*W:0]     diff;
      logic signed [ACC_W-1:0] diff_x;

      always_comb begin
        if (ODD) begin
          diff = {p2_r[K][2*W-1], p2_r[K]} - {p1_r[K][2*W-1], p1_r[K]};
        end else begin
          diff = {p1_r[K][2*W-1], p1_r[K]} - {p2_r[K][2*W-1], p2_r[K]};
        end
        diff_x = ACC_W'(diff);
      end

      always_ff @(posedge clk) begin
        if (en) begin
          p1_r[K]  <= $signed(a[C0*3+R0]) * $signed(a[C1*3+R1]);
          p2_r[K]  <= $signed(a[C1*3+R0]) * $signed(a[C0*3+R1]);
          cof_r[K] <= round_sat(diff_x);
        end
      end
    end
  end

  assign cof = cof_r;

endmodule

### rtl/m3i_det.sv
module m3i_det (
  input  logic           clk,
  input  logic           en,
  input  m3i_pkg::mat_t  a,
  input  m3i_pkg::mat_t  cof,
  output m3i_pkg::word_t det
);
  import m3i_pkg::*;

  logic signed [2*W-1:0]   p_r [3];
  logic signed [ACC_W-1:0] sum;
  word_t                   det_r;

  always_comb begin
    sum = ACC_W'(p_r[0]) + ACC_W'(p_r[1]) + ACC_W'(p_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        p_r[r] <= $signed(a[r]) * $signed(cof[r*3]);
      end
      det_r <= round_sat(sum);
    end
  end

  assign det = det_r;

endmodule

### rtl/m3i_div.sv
module m3i_div (
  input  logic           clk,
  input  logic           en,
  input  m3i_pkg::word_t num,
  input  m3i_pkg::word_t den,
  output m3i_pkg::word_t quo
);
  import m3i_pkg::*;

  logic [W-1:0]  cmag;
  logic [W-1:0]  dmag;
  logic [QB-1:0] dd;

  logic [W-1:0]  rem_r [QB+1];
  logic [QB-1:0] dq_r  [QB+1];
  logic [W-1:0]  dm_r  [QB+1];
  logic          neg_r [QB+1];
  word_t         quo_r;

  logic [QB-1:0] q;
  word_t         quo_nxt;

  always_comb begin
    cmag = num[W-1] ? (~num + W'(1)) : num;
    dmag = den[W-1] ? (~den + W'(1)) : den;
    dd   = {cmag, {FRAC_BITS{1'b0}}} + QB'(dmag >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      dq_r[0]  <= dd;
      dm_r[0]  <= dmag;
      neg_r[0] <= num[W-1] ^ den[W-1];
    end
  end

  // one restoring step per stage
  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic [W:0]   t;
    logic         ge;
    logic [W:0]   t_sub;

    always_comb begin
      t     = {rem_r[i-1], dq_r[i-1][QB-1]};
      ge    = t >= {1'b0, dm_r[i-1]};
      t_sub = t - {1'b0, dm_r[i-1]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? t_sub[W-1:0] : t[W-1:0];
        dq_r[i]  <= {dq_r[i-1][QB-2:0], ge};
        dm_r[i]  <= dm_r[i-1];
        neg_r[i] <= neg_r[i-1];
      end
    end
  end

  always_comb begin
    q = dq_r[QB];
    if (!neg_r[QB]) begin
      if (q > QB'({1'b0, {(W-1){1'b1}}})) begin
        quo_nxt = {1'b0, {(W-1){1'b1}}};
      end else begin
        quo_nxt = q[W-1:0];
      end
    end else begin
      if (q > QB'({1'b1, {(W-1){1'b0}}})) begin
        quo_nxt = {1'b1, {(W-1){1'b0}}};
      end else begin
        quo_nxt = ~q[W-1:0] + W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

### rtl/matrix3_inverse.sv
// throughput: one matrix per cycle, set by the fully pipelined multipliers
// and the nine bit-per-stage divider lanes; the whole pipe stalls together
// while a result waits on out_tready
// reset: synchronous active-low rst_n clears all valid bits and sets
// singular_epsilon to 66; no clearing pass
`include "matrix3_inverse_macros.svh"

module matrix3_inverse (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // c0r0, c0r1, c0r2, c1r0, c1r1, c1r2, c2r0, c2r1, c2r2
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // c0r0, c0r1, c0r2, c1r0, c1r1, c1r2, c2r0, c2r1, c2r2, determinant
  output logic [319:0] out_tdata,
  // singular
  output logic [0:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic [30:0]  cfg_wr_data
);
  import m3i_pkg::*;

  logic          en;
  logic [NSTG-1:0] vld_r;
  logic [W-2:0]  eps_r;

  mat_t          a_in;
  mat_t          a_pipe_r [NSTG-1];
  mat_t          cof;
  mat_t          cof_d1_r;
  mat_t          cof_d2_r;
  word_t         det;
  logic [W-1:0]  dmag;
  side_t         side_r [QB+2];
  mat_t          quo;

  mat_t          res_r;
  side_t         res_side_r;

  assign en        = !vld_r[NSTG-1] || out_tready;
  assign in_tready = en;
  assign a_in      = in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      eps_r <= (W-1)'(66);
    end else begin
      if (en) begin
        vld_r <= {vld_r[NSTG-2:0], in_tvalid};
      end
      if (cfg_wr_en) begin
        eps_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pipe_r[0] <= a_in;
      for (int i = 1; i < NSTG - 1; i++) begin
        a_pipe_r[i] <= a_pipe_r[i-1];
      end
      cof_d1_r <= cof;
      cof_d2_r <= cof_d1_r;
    end
  end

  m3i_cof u_cof (
    .clk (clk),
    .en  (en),
    .a   (a_in),
    .cof (cof)
  );

  m3i_det u_det (
    .clk (clk),
    .en  (en),
    .a   (a_pipe_r[1]),
    .cof (cof),
    .det (det)
  );

  assign dmag = det[W-1] ? (~det + W'(1)) : det;

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0].det  <= det;
      side_r[0].sing <= dmag <= {1'b0, eps_r};
      for (int i = 1; i < QB + 2; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  for (genvar k = 0; k < N_EL; k++) begin : g_lane
    m3i_div u_div (
      .clk (clk),
      .en  (en),
      .num (cof_d2_r[k]),
      .den (det),
      .quo (quo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r      <= side_r[QB+1].sing ? a_pipe_r[NSTG-2] : quo;
      res_side_r <= side_r[QB+1];
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {res_side_r.det, res_r};
  assign out_tuser  = res_side_r.sing;

  `M3I_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, vld_r[0],
    "accepted transfer did not enter the pipe")
  `M3I_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_r),
    "valid bits moved during a stall")
  `M3I_ASSERT_NOW(a_min_det_regular, out_tvalid && (out_tdata[319:288] == 32'h80000000),
    !out_tuser[0], "most negative determinant flagged singular")

endmodule

### tb/tb_matrix3_inverse.sv
module tb_matrix3_inverse;
  timeunit 1ns;
  timeprecision 1ps;
  import m3i_pkg::*;

  typedef logic signed [31:0] s32_t;
  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [31:0] el [9];
    logic [31:0] det;
    logic        sing;
  } inv_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [287:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [319:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_wr_en = 1'b0;
  logic [30:0]  cfg_wr_data = '0;

  matrix3_inverse dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  localparam int LATENCY = 55;
  localparam int WATCHDOG_LIMIT = 20000;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [30:0]  epsilon_q;
  inv_result_t  expected_inverses [$];
  int           mismatch_count = 0;
  int           idle_cycles = 0;
  bit           hold_off = 1'b0;
  int           stall_pct = 30;

  function automatic wide_t sat_word(input wide_t v);
    if (v > 128'sd2147483647) return 128'sd2147483647;
    if (v < -128'sd2147483648) return -128'sd2147483648;
    return v;
  endfunction

  function automatic wide_t round_q(input wide_t v);
    return sat_word((v + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
  endfunction

  function automatic wide_t fx_quotient(input wide_t num, input wide_t den);
    wide_t nm, dm, q;
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    nm = nm <<< FRAC_BITS;
    q = (nm + dm / 2) / dm;
    if ((num < 0) != (den < 0)) q = -q;
    return sat_word(q);
  endfunction

  function automatic inv_result_t predict_inverse(input logic [287:0] m);
    wide_t a [3][3];
    wide_t cof [3][3];
    wide_t det, mag, p;
    int r0, r1, c0, c1;
    inv_result_t res;
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++)
        a[r][c] = wide_t'(s32_t'(m[(c*3+r)*32 +: 32]));
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        r0 = (r == 0) ? 1 : 0; r1 = (r == 2) ? 1 : 2;
        c0 = (c == 0) ? 1 : 0; c1 = (c == 2) ? 1 : 2;
        p = a[r0][c0] * a[r1][c1] - a[r0][c1] * a[r1][c0];
        if ((r + c) % 2 == 1) p = -p;
        cof[r][c] = round_q(p);
      end
    det = round_q(a[0][0] * cof[0][0] + a[1][0] * cof[1][0] + a[2][0] * cof[2][0]);
    mag = (det < 0) ? -det : det;
    res.sing = (mag <= wide_t'(epsilon_q));
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++)
        res.el[c*3+r] = 32'(res.sing ? a[r][c] : fx_quotient(cof[c][r], det));
    res.det = det[31:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    inv_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_inverses.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], 32'h0);
      end else begin
        want = expected_inverses.pop_front();
        for (int i = 0; i < 9; i++)
          if (out_tdata[i*32 +: 32] !== want.el[i])
            report_mismatch($sformatf("element %0d", i), out_tdata[i*32 +: 32], want.el[i]);
        if (out_tdata[319:288] !== want.det)
          report_mismatch("determinant", out_tdata[319:288], want.det);
        if (out_tuser[0] !== want.sing)
          report_mismatch("singular", {31'b0, out_tuser[0]}, {31'b0, want.sing});
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= stall_pct);
  end

  int burst_left = 0;

  task automatic send_matrix(input logic [287:0] m);
    if (burst_left == 0) begin
      burst_left = $urandom_range(20, 1);
      if ($urandom_range(3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(6, 1)) @(negedge clk);
      end
    end
    burst_left--;
    in_tdata <= m;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_inverses.push_back(predict_inverse(m));
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (expected_inverses.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_epsilon(input logic [30:0] v);
    drain_pipe();
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    epsilon_q = v;
  endtask

  function automatic logic [31:0] diag_word(input logic [31:0] d, input int i);
    return (i == 0 || i == 4 || i == 8) ? d : 32'h0;
  endfunction

  function automatic logic [31:0] rand_element();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      default: return 32'($signed($urandom_range(1 << 18)) - (1 << 17));
    endcase
  endfunction

  task automatic test_directed();
    logic [287:0] m;
    for (int i = 0; i < 9; i++) m[i*32 +: 32] = diag_word(32'h00010000, i);
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i*32 +: 32] = diag_word(32'hffff0000, i);
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i*32 +: 32] = diag_word(32'h00020000, i);
    send_matrix(m);
    send_matrix('0);
    send_matrix({9{32'h7fffffff}});
    send_matrix({9{32'h80000000}});
    send_matrix({9{32'hffffffff}});
    for (int i = 0; i < 9; i++) m[i*32 +: 32] = diag_word(32'h80000000, i);
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i*32 +: 32] = diag_word(32'h7fffffff, i);
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i*32 +: 32] = diag_word(32'h00000100, i);
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i*32 +: 32] = diag_word(32'h00000080, i);
    send_matrix(m);
    // most negative determinant
    for (int i = 0; i < 9; i++) m[i*32 +: 32] = diag_word(32'h00000000, i);
    m[0 +: 32] = 32'hff800000; m[4*32 +: 32] = 32'h01000000; m[8*32 +: 32] = 32'h00800000;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i*32 +: 32] = 32'(i << 16);
    send_matrix(m);
    m = {32'h00010000, 32'h00020000, 32'h00030000, 32'h00000000, 32'h00010000,
         32'h00040000, 32'h00050000, 32'h00060000, 32'h00000000};
    send_matrix(m);
    drain_pipe();
  endtask

  task automatic test_epsilon_settings();
    logic [287:0] m;
    logic [30:0] eps_set [4] = '{31'h0, 31'h7fffffff, 31'd66, 31'h00010000};
    foreach (eps_set[k]) begin
      write_epsilon(eps_set[k]);
      for (int j = 0; j < 12; j++) begin
        for (int i = 0; i < 9; i++)
          m[i*32 +: 32] = diag_word(32'($urandom_range(3 << 16)), i) | 32'($urandom_range(3));
        send_matrix(m);
      end
    end
    write_epsilon(31'd66);
  endtask

  task automatic test_random_stream();
    logic [287:0] m;
    for (int n = 0; n < 1570; n++) begin
      if (n == 850) write_epsilon(31'($urandom) & 31'h0003ffff);
      if (n == 1300) write_epsilon(31'd66);
      for (int i = 0; i < 9; i++) m[i*32 +: 32] = rand_element();
      if ($urandom_range(4) == 0)
        for (int i = 0; i < 3; i++) m[(6+i)*32 +: 32] = m[i*32 +: 32];
      stall_pct = (n / 200) % 2 ? 0 : 30;
      send_matrix(m);
    end
    drain_pipe();
  endtask

  task automatic test_backpressure();
    logic [287:0] m;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 120; n++) begin
        for (int i = 0; i < 9; i++) m[i*32 +: 32] = rand_element();
        send_matrix(m);
      end
    join
    drain_pipe();
  endtask

  initial begin
    epsilon_q = 31'd66;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_epsilon_settings();
    test_backpressure();
    test_random_stream();
    if (mismatch_count == 0 && expected_inverses.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
